### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check, held off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants and types of the direct-mapped cache tag check unit.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_LINES_DEF = 1024;

    localparam int ADDR_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 32;

    // Result beat: hit, hit_total, miss_total, padded to whole bytes
    localparam int RES_W     = 1 + 2 * CNT_W;
    localparam int RES_BYTES = (RES_W + 7) / 8;
    localparam int OUT_W     = RES_BYTES * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;

    // Queue fill status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/direct_mapped_cache_tag_check_unit.sv
// Direct-mapped cache tag check. Each address beat is split by the offset and
// index widths into a line index and a tag; the line's valid bit and tag are
// looked up, a hit is reported on a valid matching line, and a miss fills the
// line with the new tag. Each address gives one result beat with the hit flag
// and saturating running hit and miss totals. For each address the back end
// first does the registered line-store read, then the compare and fill, which
// waits while the result register is still full; it takes no new address
// until it is through with the last. A two-entry queue lets the front keep
// taking addresses while a result waits. After reset the line store is swept
// clear, one line a cycle over all 2^floor(log2 MAX_LINES) lines (1024 by
// default), and no address is taken until then. Configuration writes are
// taken at any time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_unit
// Top level: configuration port, address stream in, result stream out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_cache_tag_check_unit #(
    parameter int MAX_LINES = dmc_pkg::MAX_LINES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [dmc_pkg::CFG_W-1:0]     i_cfg_data,
    // address stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_s_axis_tdata,  // [31:0] address
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [dmc_pkg::OUT_W-1:0]     o_m_axis_tdata   // [0] hit, [32:1] hit_total,
                                                           // [64:33] miss_total, rest zero
);

    localparam int MAX_B   = $clog2(MAX_LINES + 1) - 1;
    localparam int LINE_AW = (MAX_B == 0) ? 1 : MAX_B;
    localparam int LINES   = 1 << MAX_B;
    localparam int Q_W     = LINE_AW + dmc_pkg::ADDR_W;

    logic                       w_push;
    logic                       w_pop;
    logic                       w_clearing;
    logic [LINE_AW-1:0]         w_f_line;
    logic [dmc_pkg::ADDR_W-1:0] w_f_tag;
    logic [Q_W-1:0]             w_q_out;
    dmc_pkg::t_q_stat           w_q_stat;

    dmc_front #(
        .MAX_B   (MAX_B),
        .LINE_AW (LINE_AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_addr      (i_s_axis_tdata),
        .i_clearing  (w_clearing),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_line      (w_f_line),
        .o_tag       (w_f_tag)
    );

    dmc_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_tag, w_f_line}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_q_stat)
    );

    dmc_back #(
        .LINES   (LINES),
        .LINE_AW (LINE_AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_line     (w_q_out[LINE_AW-1:0]),
        .i_tag      (w_q_out[Q_W-1:LINE_AW]),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata)
    );

    `ASSERT_IMPL(a_no_accept_clearing, i_clk, i_rst_n, w_clearing, !o_s_axis_tready, "address taken during clear sweep")
    `ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, w_push, !w_q_stat.full || w_pop, "queue push while full")
    `ASSERT_IMPL(a_q_no_underflow, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "queue pop while empty")
    `ASSERT_IMPL(a_no_result_clearing, i_clk, i_rst_n, w_clearing, !o_m_axis_tvalid, "result during clear sweep")

endmodule

### rtl/dmc_queue.sv
// ----------------------------------------------------------------------------
// dmc_queue
// Two-entry queue between the front (address split) and the back (lookup).
// ----------------------------------------------------------------------------
module dmc_queue #(
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output dmc_pkg::t_q_stat  o_stat
);

    logic [DATA_W-1:0] r_data [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_data[r_rd_ptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

### rtl/dmc_front.sv
// ----------------------------------------------------------------------------
// dmc_front
// Holds the split widths, takes address beats and splits each into a line
// index and a tag for the lookup queue.
// ----------------------------------------------------------------------------
module dmc_front #(
    parameter int MAX_B   = 10,
    parameter int LINE_AW = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [dmc_pkg::CFG_W-1:0]     i_cfg_data,
    // address beats
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_addr,
    // queue side
    input  logic                          i_clearing,
    input  dmc_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output logic [LINE_AW-1:0]            o_line,
    output logic [dmc_pkg::ADDR_W-1:0]    o_tag
);

    logic [dmc_pkg::CFG_W-1:0] r_offset_bits;
    logic [dmc_pkg::CFG_W-1:0] r_index_bits;
    logic [4:0]                w_ib;
    logic [4:0]                w_tag_sh;
    logic [dmc_pkg::ADDR_W-1:0] w_sh_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= dmc_pkg::OFFSET_BITS_RST;
            r_index_bits  <= dmc_pkg::INDEX_BITS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                dmc_pkg::REG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                dmc_pkg::REG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Clamp the index width to what the line store holds
    always_comb begin
        if ({1'b0, r_index_bits} > 5'(MAX_B)) begin
            w_ib = 5'(MAX_B);
        end else begin
            w_ib = {1'b0, r_index_bits};
        end
        w_tag_sh  = 5'({1'b0, r_offset_bits} + w_ib);
        w_sh_addr = i_addr >> r_offset_bits;
    end

    assign o_line  = LINE_AW'(w_sh_addr) & ~({LINE_AW{1'b1}} << w_ib);
    assign o_tag   = i_addr >> w_tag_sh;
    assign o_ready = !i_q_stat.full && !i_clearing;
    assign o_push  = i_valid && o_ready;

endmodule

### rtl/dmc_back.sv
// ----------------------------------------------------------------------------
// dmc_back
// Line store, tag compare, fill on miss, saturating counters and the result
// register.
// ----------------------------------------------------------------------------
module dmc_back #(
    parameter int LINES   = 1024,
    parameter int LINE_AW = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // queue side
    input  dmc_pkg::t_q_stat           i_q_stat,
    input  logic [LINE_AW-1:0]         i_line,
    input  logic [dmc_pkg::ADDR_W-1:0] i_tag,
    output logic                       o_pop,
    output logic                       o_clearing,
    // result beats
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [dmc_pkg::OUT_W-1:0]  o_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    localparam int ENT_W = dmc_pkg::ADDR_W + 1;

    t_state                      r_state;
    logic [LINE_AW-1:0]          r_clr_idx;
    logic [LINE_AW-1:0]          r_line;
    logic [dmc_pkg::ADDR_W-1:0]  r_tag;
    logic [ENT_W-1:0]            r_mem [LINES];
    logic [ENT_W-1:0]            r_rd_data;
    logic [dmc_pkg::CNT_W-1:0]   r_hits;
    logic [dmc_pkg::CNT_W-1:0]   r_misses;
    logic                        r_out_valid;
    logic                        r_out_hit;

    logic                        w_hit;
    logic                        w_can_out;
    logic                        w_finish;
    logic                        w_we;
    logic [LINE_AW-1:0]          w_wa;
    logic [ENT_W-1:0]            w_wd;
    logic [dmc_pkg::CNT_W-1:0]   n_hits;
    logic [dmc_pkg::CNT_W-1:0]   n_misses;

    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign w_hit      = r_rd_data[ENT_W-1] && (r_rd_data[dmc_pkg::ADDR_W-1:0] == r_tag);
    assign w_can_out  = !r_out_valid || i_ready;
    assign w_finish   = (r_state == S_LOOK) && w_can_out;

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (w_hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + 1'b1;
            end
        end else begin
            if (r_misses != '1) begin
                n_misses = r_misses + 1'b1;
            end
        end
    end

    // Write port: clearing sweep, or fill on miss
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr_idx;
            w_wd = '0;
        end else begin
            w_we = w_finish && !w_hit;
            w_wa = r_line;
            w_wd = {1'b1, r_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[i_line];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LINE_AW'(LINES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_line  <= i_line;
                        r_tag   <= i_tag;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // hold the read data until the result register frees up
                    if (w_can_out) begin
                        r_hits      <= n_hits;
                        r_misses    <= n_misses;
                        r_out_hit   <= w_hit;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = dmc_pkg::OUT_W'({r_misses, r_hits, r_out_hit});

endmodule

### sim/direct_mapped_cache_tag_check_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_unit_tb
// Self-checking bench for the cache tag check unit. A table of directed
// lookups and register writes runs first. Phases of random lookups follow,
// each under its own offset and index widths. Random gaps are applied on the
// address side and the result side. A shadow copy of the line store and the
// counters predicts every result beat, and each beat is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check_unit_tb;

    localparam int     ADDR_W      = dmc_pkg::ADDR_W;
    localparam int     CNT_W       = dmc_pkg::CNT_W;
    localparam int     CFG_W       = dmc_pkg::CFG_W;
    localparam int     CFG_IDX_W   = dmc_pkg::CFG_IDX_W;
    localparam int     OUT_W       = dmc_pkg::OUT_W;
    localparam int     PAD_W       = dmc_pkg::OUT_W - dmc_pkg::RES_W;
    localparam int     LINE_COUNT  = dmc_pkg::MAX_LINES_DEF;
    localparam int     INDEX_CAP   = $clog2(LINE_COUNT + 1) - 1;   // floor(log2(lines))
    localparam int     RAND_PHASES = 10;
    localparam int     PHASE_ITEMS = 145;
    localparam int     HOT_SIZE    = 16;
    localparam int     HOT_AW      = $clog2(HOT_SIZE);
    localparam int     DRAIN_WAIT  = 8;
    // several times the slowest legal run, post-reset line sweep included
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] hit_total;
        logic             hit;
    } t_lookup_result;

    typedef enum logic {ROW_ACCESS, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] sel;
        logic [ADDR_W-1:0]    value;
        logic                 typed;
        logic                 hit;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
    } t_dir_row;

    // Fixed expectations only for the cold-start rows under reset widths
    localparam t_dir_row DIRECTED [26] = '{
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b1, 1'b0, 32'd0, 32'd1},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_000F, 1'b1, 1'b1, 32'd1, 32'd1},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'd1, 32'd2},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_FFF0, 1'b1, 1'b1, 32'd2, 32'd2},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_1000, 1'b1, 1'b0, 32'd2, 32'd3},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b1, 1'b0, 32'd2, 32'd4},
        // narrowest split: every address lands on line zero
        '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 32'd0,         1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  32'd0,         1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
        // largest offset, index wider than the store
        '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 32'd15,        1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  32'd15,        1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_8000, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 32'd12,        1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  32'd10,        1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hFFFF_F000, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h0000_0ABC, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_OFFSET_BITS, 32'd13,        1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_WRITE,  dmc_pkg::REG_INDEX_BITS,  32'd9,         1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h5555_5555, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0, 32'd0},
        '{ROW_ACCESS, dmc_pkg::REG_OFFSET_BITS, 32'h5555_5555, 1'b0, 1'b0, 32'd0, 32'd0}
    };

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_addr      = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [ADDR_W-1:0]    i_s_axis_tdata  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;

    // Shadow of the line store, counters and widths
    logic [LINE_COUNT-1:0] shadow_valid = '0;
    logic [ADDR_W-1:0]     shadow_tag [LINE_COUNT];
    logic [CNT_W-1:0]      shadow_hits = '0;
    logic [CNT_W-1:0]      shadow_misses = '0;
    logic [CFG_W-1:0]      shadow_offset_bits = dmc_pkg::OFFSET_BITS_RST;
    logic [CFG_W-1:0]      shadow_index_bits = dmc_pkg::INDEX_BITS_RST;

    t_lookup_result        pending_lookups [$];
    logic [ADDR_W-1:0]     hot_addrs [HOT_SIZE];
    bit                    addr_burst = 1'b0;
    int                    ready_stall = 0;
    longint                cycle_count = 0;
    int                    failures = 0;
    int                    addresses_sent = 0;
    int                    results_seen = 0;
    int                    hits_observed = 0;
    int                    config_writes = 0;

    direct_mapped_cache_tag_check_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int unsigned index_width();
        return (shadow_index_bits > INDEX_CAP) ? INDEX_CAP : shadow_index_bits;
    endfunction

    // Look up one address in the shadow store, fill on a miss, bump counters
    function automatic t_lookup_result predict_lookup(input logic [ADDR_W-1:0] addr);
        int unsigned          ib;
        logic [INDEX_CAP-1:0] line;
        logic [ADDR_W-1:0]    tag;
        t_lookup_result       res;
        ib   = index_width();
        line = INDEX_CAP'((addr >> shadow_offset_bits) & ((32'd1 << ib) - 32'd1));
        tag  = addr >> (shadow_offset_bits + ib);
        res  = '0;
        res.hit = shadow_valid[line] && (shadow_tag[line] == tag);
        if (res.hit) begin
            if (shadow_hits != '1) shadow_hits++;
        end else begin
            shadow_valid[line] = 1'b1;
            shadow_tag[line]   = tag;
            if (shadow_misses != '1) shadow_misses++;
        end
        res.hit_total  = shadow_hits;
        res.miss_total = shadow_misses;
        return res;
    endfunction

    // Mostly revisits and conflicts on a small set of hot lines
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned       r;
        logic [HOT_AW-1:0] k;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] tag_mask;
        r        = $urandom_range(99);
        k        = HOT_AW'($urandom_range(HOT_SIZE - 1));
        low_mask = (32'd1 << shadow_offset_bits) - 32'd1;
        tag_mask = ~((32'd1 << (shadow_offset_bits + index_width())) - 32'd1);
        if (r < 50) return hot_addrs[k] ^ ($urandom & low_mask);
        if (r < 70) return (hot_addrs[k] & ~tag_mask) | ($urandom & tag_mask);
        if (r < 80) begin
            hot_addrs[k] = $urandom;
            return hot_addrs[k];
        end
        return $urandom;
    endfunction

    task automatic send_address(input logic [ADDR_W-1:0] addr, input logic typed,
                                input t_lookup_result typed_res);
        int             gap;
        t_lookup_result res;
        gap = pick_gap(addr_burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        res = predict_lookup(addr);
        pending_lookups.push_back(typed ? typed_res : res);
        addresses_sent++;
    endtask

    // Write only once the pipe has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (sel == dmc_pkg::REG_OFFSET_BITS) shadow_offset_bits = data;
        else if (sel == dmc_pkg::REG_INDEX_BITS) shadow_index_bits = data;
        config_writes++;
    endtask

    task automatic report_field(input string name, input logic [CNT_W-1:0] want,
                                input logic [CNT_W-1:0] got);
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        failures++;
    endtask

    // Result side: check each beat, then pick the next ready
    always @(posedge i_clk) begin
        t_lookup_result got;
        t_lookup_result want;
        cycle_count++;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_lookup_result'(o_m_axis_tdata);
            if (pending_lookups.size() == 0) begin
                $display("%0t: result beat with nothing expected: expected none, got %h",
                         $time, o_m_axis_tdata);
                failures++;
            end else begin
                want = pending_lookups.pop_front();
                if (got.hit !== want.hit)
                    report_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
                if (got.hit_total !== want.hit_total)
                    report_field("hit_total", want.hit_total, got.hit_total);
                if (got.miss_total !== want.miss_total)
                    report_field("miss_total", want.miss_total, got.miss_total);
                if (got.pad !== want.pad)
                    report_field("padding", CNT_W'(want.pad), CNT_W'(got.pad));
                results_seen++;
                if (got.hit === 1'b1) hits_observed++;
            end
        end
        if (ready_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            ready_stall--;
        end else begin
            i_m_axis_tready <= 1'b1;
            ready_stall = pick_gap((cycle_count % 2000) < 400);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_lookup_result   typed_res;
        logic [CFG_W-1:0] off_sel;
        logic [CFG_W-1:0] idx_sel;
        foreach (hot_addrs[k]) hot_addrs[k] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].kind == ROW_WRITE) begin
                write_reg(DIRECTED[k].sel, DIRECTED[k].value[CFG_W-1:0]);
            end else begin
                typed_res            = '0;
                typed_res.hit        = DIRECTED[k].hit;
                typed_res.hit_total  = DIRECTED[k].hit_total;
                typed_res.miss_total = DIRECTED[k].miss_total;
                send_address(DIRECTED[k].value, DIRECTED[k].typed, typed_res);
            end
        end

        // First phases pin the width extremes and the reset widths, the rest draw at random
        for (int p = 0; p < RAND_PHASES; p++) begin
            off_sel = (p == 0) ? 4'd0 : (p == 1) ? 4'd12 : (p == 2) ? 4'd15 :
                      (p == 3) ? dmc_pkg::OFFSET_BITS_RST : CFG_W'($urandom_range(15));
            idx_sel = (p == 0) ? 4'd0 : (p == 1) ? 4'd10 : (p == 2) ? 4'd15 :
                      (p == 3) ? dmc_pkg::INDEX_BITS_RST : CFG_W'($urandom_range(15));
            write_reg(dmc_pkg::REG_OFFSET_BITS, off_sel);
            write_reg(dmc_pkg::REG_INDEX_BITS, idx_sel);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                addr_burst = (n % 70) < 15;
                send_address(pick_address(), 1'b0, '0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d addresses, checked %0d lookups (%0d hits, %0d misses), %0d writes",
                 addresses_sent, results_seen, hits_observed, results_seen - hits_observed,
                 config_writes);
        $display("Directed cold, conflict and width-extreme cases, then %0d random phases",
                 RAND_PHASES);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
